/* rtl/core/esc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_pkg
// shared types, opcodes and constants of the compensation core
// ----------------------------------------------------------------------------
package esc_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 64;
    localparam int MicroW   = 7;

    localparam logic [CfgIdxW-1:0] REG_TEMP_TRIM  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_PRESS_A    = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_PRESS_B    = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_PRESS_C    = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_HUM_TRIM   = 3'd4;

    localparam logic [19:0] TEMP_SKIP  = 20'h80000;
    localparam logic [19:0] PRESS_SKIP = 20'h80000;
    localparam logic [15:0] HUM_SKIP   = 16'h8000;
    localparam logic [31:0] HUM_MAX    = 32'd419430400;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DIV,
        ST_OUT
    } state_t;

    // operand sources
    typedef enum logic [3:0] {
        SRC_R0, SRC_R1, SRC_R2, SRC_R3, SRC_R4, SRC_R5, SRC_R6, SRC_R7,
        SRC_CONST, SRC_ZERO
    } src_t;

    // alu operations
    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_ASR,
        OP_LSR,
        OP_SHL
    } op_t;

    typedef struct packed {
        op_t         op;
        src_t        a;
        src_t        b;
        logic [2:0]  dst;
        logic [31:0] k;
    } uop_t;

    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
    } div_rsp_t;

endpackage

/* rtl/core/esc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_in_if / esc_out_if / esc_cfg_if
// valid-ready channels of the compensation core
// ----------------------------------------------------------------------------
interface esc_in_if;
    logic        valid;
    logic        ready;
    logic [19:0] adc_temp;
    logic [19:0] adc_press;
    logic [15:0] adc_hum;
    modport source (output valid, adc_temp, adc_press, adc_hum, input ready);
    modport sink   (input valid, adc_temp, adc_press, adc_hum, output ready);
endinterface

interface esc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] temp_centi;
    logic [31:0] press_pa;
    logic [16:0] hum_q10;
    logic        temp_ok;
    logic        press_ok;
    logic        hum_ok;
    modport source (output valid, temp_centi, press_pa, hum_q10, temp_ok, press_ok,
                    hum_ok, input ready);
    modport sink   (input valid, temp_centi, press_pa, hum_q10, temp_ok, press_ok,
                    hum_ok, output ready);
endinterface

interface esc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/esc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_div
// unsigned 32-bit restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module esc_div
    import esc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [31:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[31:0], quo_reg[31]};
        if (req.start)
        begin
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

/* rtl/core/esc_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_alu
// shared 32-bit arithmetic unit with a register file of eight words
// ----------------------------------------------------------------------------
module esc_alu
    import esc_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  uop_t        uop,
    input  logic        ld,
    input  logic [2:0]  ld_dst,
    input  logic [31:0] ld_val,
    output logic [31:0] rf [8]
);

    logic [31:0] rf_reg [8];
    logic [31:0] a, b, y;
    logic [63:0] prod;

    function automatic logic [31:0] pick(input src_t s, input logic [31:0] k,
                                         input logic [31:0] r [8]);
        logic [31:0] v;
        case (s)
            SRC_R0:    v = r[0];
            SRC_R1:    v = r[1];
            SRC_R2:    v = r[2];
            SRC_R3:    v = r[3];
            SRC_R4:    v = r[4];
            SRC_R5:    v = r[5];
            SRC_R6:    v = r[6];
            SRC_R7:    v = r[7];
            SRC_CONST: v = k;
            default:   v = '0;
        endcase
        return v;
    endfunction

    always_comb
    begin
        a    = pick(uop.a, uop.k, rf_reg);
        b    = pick(uop.b, uop.k, rf_reg);
        prod = a * b;
        case (uop.op)
            OP_ADD:  y = a + b;
            OP_SUB:  y = a - b;
            OP_MUL:  y = prod[31:0];
            OP_ASR:  y = 32'($signed(a) >>> b[4:0]);
            OP_LSR:  y = a >> b[4:0];
            OP_SHL:  y = a << b[4:0];
            default: y = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ld)
            rf_reg[ld_dst] <= ld_val;
        else if (en)
            rf_reg[uop.dst] <= y;
    end

    assign rf = rf_reg;

endmodule

/* rtl/core/esc_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_seq
// microcode sequencer driving the shared alu and divider
// ----------------------------------------------------------------------------
module esc_seq
    import esc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    esc_in_if.sink            in_ch,
    esc_out_if.source         out_ch,
    input  logic [47:0]       temp_trim,
    input  logic [47:0]       press_a,
    input  logic [47:0]       press_b,
    input  logic [47:0]       press_c,
    input  logic [63:0]       hum_trim,
    output logic              busy
);

    // microprogram regions
    localparam logic [MicroW-1:0] T_BEG = 7'd0;
    localparam logic [MicroW-1:0] T_END = 7'd17;
    localparam logic [MicroW-1:0] P_BEG = 7'd18;
    localparam logic [MicroW-1:0] P_DEN = 7'd43;  // divisor and dividend ready
    localparam logic [MicroW-1:0] P_DIV = 7'd44;  // first step after the division
    localparam logic [MicroW-1:0] P_END = 7'd64;
    localparam logic [MicroW-1:0] H_BEG = 7'd65;
    localparam logic [MicroW-1:0] H_END = 7'd101;
    // operand load steps ahead of each channel
    localparam logic [MicroW-1:0] T_LD  = 7'd110;
    localparam logic [MicroW-1:0] P_LD  = 7'd111;
    localparam logic [MicroW-1:0] H_LD  = 7'd112;

    state_t state_reg, state_next;
    logic [MicroW-1:0] pc_reg, pc_next;
    logic [31:0] fine_reg, fine_next;
    logic [19:0] at_reg, ap_reg;
    logic [15:0] ah_reg;
    logic [31:0] t_reg, p_reg;
    logic [16:0] h_reg;
    logic tok_reg, pok_reg, hok_reg;
    logic tdo, pdo, hdo;
    logic [31:0] rf [8];
    uop_t uop;
    logic en, ld;
    logic [2:0] ld_dst;
    logic [31:0] ld_val;
    div_req_t dreq;
    div_rsp_t drsp;
    logic [31:0] hx;

    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;

    assign t1 = {16'd0, temp_trim[15:0]};
    assign t2 = {{16{temp_trim[31]}}, temp_trim[31:16]};
    assign t3 = {{16{temp_trim[47]}}, temp_trim[47:32]};
    assign p1 = {16'd0, press_a[15:0]};
    assign p2 = {{16{press_a[31]}}, press_a[31:16]};
    assign p3 = {{16{press_a[47]}}, press_a[47:32]};
    assign p4 = {{16{press_b[15]}}, press_b[15:0]};
    assign p5 = {{16{press_b[31]}}, press_b[31:16]};
    assign p6 = {{16{press_b[47]}}, press_b[47:32]};
    assign p7 = {{16{press_c[15]}}, press_c[15:0]};
    assign p8 = {{16{press_c[31]}}, press_c[31:16]};
    assign p9 = {{16{press_c[47]}}, press_c[47:32]};
    assign h1 = {24'd0, hum_trim[7:0]};
    assign h2 = {{16{hum_trim[23]}}, hum_trim[23:8]};
    assign h3 = {24'd0, hum_trim[31:24]};
    assign h4 = {{20{hum_trim[43]}}, hum_trim[43:32]};
    assign h5 = {{20{hum_trim[55]}}, hum_trim[55:44]};
    assign h6 = {{24{hum_trim[63]}}, hum_trim[63:56]};

    function automatic uop_t u(input op_t o, input src_t a, input src_t b,
                               input logic [2:0] d, input logic [31:0] k);
        uop_t r;
        r.op = o; r.a = a; r.b = b; r.dst = d; r.k = k;
        return r;
    endfunction

    // microprogram: one alu operation per step
    always_comb
    begin
        case (pc_reg)
            // temperature
            7'd0:  uop = u(OP_LSR, SRC_R0, SRC_CONST, 3'd1, 32'd3);
            7'd1:  uop = u(OP_SHL, SRC_CONST, SRC_CONST, 3'd2, t1 << 1);
            7'd2:  uop = u(OP_SUB, SRC_R1, SRC_CONST, 3'd1, t1 << 1);
            7'd3:  uop = u(OP_MUL, SRC_R1, SRC_CONST, 3'd1, t2);
            7'd4:  uop = u(OP_ASR, SRC_R1, SRC_CONST, 3'd1, 32'd11);
            7'd5:  uop = u(OP_LSR, SRC_R0, SRC_CONST, 3'd2, 32'd4);
            7'd6:  uop = u(OP_SUB, SRC_R2, SRC_CONST, 3'd2, t1);
            7'd7:  uop = u(OP_MUL, SRC_R2, SRC_R2, 3'd2, 32'd0);
            7'd8:  uop = u(OP_ASR, SRC_R2, SRC_CONST, 3'd2, 32'd12);
            7'd9:  uop = u(OP_MUL, SRC_R2, SRC_CONST, 3'd2, t3);
            7'd10: uop = u(OP_ASR, SRC_R2, SRC_CONST, 3'd2, 32'd14);
            7'd11: uop = u(OP_ADD, SRC_R1, SRC_R2, 3'd7, 32'd0);
            7'd12: uop = u(OP_MUL, SRC_R7, SRC_CONST, 3'd1, 32'd5);
            7'd13: uop = u(OP_ADD, SRC_R1, SRC_CONST, 3'd1, 32'd128);
            7'd14: uop = u(OP_ASR, SRC_R1, SRC_CONST, 3'd1, 32'd8);
            7'd15: uop = u(OP_ADD, SRC_R1, SRC_ZERO, 3'd1, 32'd0);
            7'd16: uop = u(OP_ADD, SRC_R1, SRC_ZERO, 3'd1, 32'd0);
            7'd17: uop = u(OP_ADD, SRC_R1, SRC_ZERO, 3'd1, 32'd0);
            // pressure: r7 fine, r0 adc
            7'd18: uop = u(OP_ASR, SRC_R7, SRC_CONST, 3'd1, 32'd1);
            7'd19: uop = u(OP_SUB, SRC_R1, SRC_CONST, 3'd1, 32'd64000);
            7'd20: uop = u(OP_ASR, SRC_R1, SRC_CONST, 3'd2, 32'd2);
            7'd21: uop = u(OP_MUL, SRC_R2, SRC_R2, 3'd2, 32'd0);
            7'd22: uop = u(OP_ASR, SRC_R2, SRC_CONST, 3'd3, 32'd11);
            7'd23: uop = u(OP_MUL, SRC_R3, SRC_CONST, 3'd3, p6);
            7'd24: uop = u(OP_MUL, SRC_R1, SRC_CONST, 3'd4, p5);
            7'd25: uop = u(OP_SHL, SRC_R4, SRC_CONST, 3'd4, 32'd1);
            7'd26: uop = u(OP_ADD, SRC_R3, SRC_R4, 3'd3, 32'd0);
            7'd27: uop = u(OP_ASR, SRC_R3, SRC_CONST, 3'd3, 32'd2);
            7'd28: uop = u(OP_ADD, SRC_R3, SRC_CONST, 3'd3, p4 << 16);
            7'd29: uop = u(OP_ASR, SRC_R2, SRC_CONST, 3'd2, 32'd13);
            7'd30: uop = u(OP_MUL, SRC_R2, SRC_CONST, 3'd2, p3);
            7'd31: uop = u(OP_ASR, SRC_R2, SRC_CONST, 3'd2, 32'd3);
            7'd32: uop = u(OP_MUL, SRC_R1, SRC_CONST, 3'd1, p2);
            7'd33: uop = u(OP_ASR, SRC_R1, SRC_CONST, 3'd1, 32'd1);
            7'd34: uop = u(OP_ADD, SRC_R1, SRC_R2, 3'd1, 32'd0);
            7'd35: uop = u(OP_ASR, SRC_R1, SRC_CONST, 3'd1, 32'd18);
            7'd36: uop = u(OP_ADD, SRC_R1, SRC_CONST, 3'd1, 32'd32768);
            7'd37: uop = u(OP_MUL, SRC_R1, SRC_CONST, 3'd1, p1);
            7'd38: uop = u(OP_ASR, SRC_R1, SRC_CONST, 3'd1, 32'd15);
            7'd39: uop = u(OP_SUB, SRC_CONST, SRC_R0, 3'd2, 32'd1048576);
            7'd40: uop = u(OP_ASR, SRC_R3, SRC_CONST, 3'd3, 32'd12);
            7'd41: uop = u(OP_SUB, SRC_R2, SRC_R3, 3'd2, 32'd0);
            7'd42: uop = u(OP_MUL, SRC_R2, SRC_CONST, 3'd2, 32'd3125);
            7'd43: uop = u(OP_SHL, SRC_R2, SRC_CONST, 3'd3, 32'd1);
            // r2 = p after division
            7'd44: uop = u(OP_LSR, SRC_R2, SRC_CONST, 3'd3, 32'd3);
            7'd45: uop = u(OP_MUL, SRC_R3, SRC_R3, 3'd3, 32'd0);
            7'd46: uop = u(OP_LSR, SRC_R3, SRC_CONST, 3'd3, 32'd13);
            7'd47: uop = u(OP_MUL, SRC_R3, SRC_CONST, 3'd3, p9);
            7'd48: uop = u(OP_ASR, SRC_R3, SRC_CONST, 3'd3, 32'd12);
            7'd49: uop = u(OP_LSR, SRC_R2, SRC_CONST, 3'd4, 32'd2);
            7'd50: uop = u(OP_MUL, SRC_R4, SRC_CONST, 3'd4, p8);
            7'd51: uop = u(OP_ASR, SRC_R4, SRC_CONST, 3'd4, 32'd13);
            7'd52: uop = u(OP_ADD, SRC_R3, SRC_R4, 3'd3, 32'd0);
            7'd53: uop = u(OP_ADD, SRC_R3, SRC_CONST, 3'd3, p7);
            7'd54: uop = u(OP_ASR, SRC_R3, SRC_CONST, 3'd3, 32'd4);
            7'd55: uop = u(OP_ADD, SRC_R2, SRC_R3, 3'd2, 32'd0);
            // humidity: r6 adc
            7'd65: uop = u(OP_SUB, SRC_R7, SRC_CONST, 3'd1, 32'd76800);
            7'd66: uop = u(OP_SHL, SRC_R6, SRC_CONST, 3'd2, 32'd14);
            7'd67: uop = u(OP_SUB, SRC_R2, SRC_CONST, 3'd2, h4 << 20);
            7'd68: uop = u(OP_MUL, SRC_R1, SRC_CONST, 3'd3, h5);
            7'd69: uop = u(OP_SUB, SRC_R2, SRC_R3, 3'd2, 32'd0);
            7'd70: uop = u(OP_ADD, SRC_R2, SRC_CONST, 3'd2, 32'd16384);
            7'd71: uop = u(OP_ASR, SRC_R2, SRC_CONST, 3'd2, 32'd15);
            7'd72: uop = u(OP_MUL, SRC_R1, SRC_CONST, 3'd3, h6);
            7'd73: uop = u(OP_ASR, SRC_R3, SRC_CONST, 3'd3, 32'd10);
            7'd74: uop = u(OP_MUL, SRC_R1, SRC_CONST, 3'd4, h3);
            7'd75: uop = u(OP_ASR, SRC_R4, SRC_CONST, 3'd4, 32'd11);
            7'd76: uop = u(OP_ADD, SRC_R4, SRC_CONST, 3'd4, 32'd32768);
            7'd77: uop = u(OP_MUL, SRC_R3, SRC_R4, 3'd3, 32'd0);
            7'd78: uop = u(OP_ASR, SRC_R3, SRC_CONST, 3'd3, 32'd10);
            7'd79: uop = u(OP_ADD, SRC_R3, SRC_CONST, 3'd3, 32'd2097152);
            7'd80: uop = u(OP_MUL, SRC_R3, SRC_CONST, 3'd3, h2);
            7'd81: uop = u(OP_ADD, SRC_R3, SRC_CONST, 3'd3, 32'd8192);
            7'd82: uop = u(OP_ASR, SRC_R3, SRC_CONST, 3'd3, 32'd14);
            7'd83: uop = u(OP_MUL, SRC_R2, SRC_R3, 3'd2, 32'd0);
            7'd84: uop = u(OP_ASR, SRC_R2, SRC_CONST, 3'd3, 32'd15);
            7'd85: uop = u(OP_MUL, SRC_R3, SRC_R3, 3'd3, 32'd0);
            7'd86: uop = u(OP_ASR, SRC_R3, SRC_CONST, 3'd3, 32'd7);
            7'd87: uop = u(OP_MUL, SRC_R3, SRC_CONST, 3'd3, h1);
            7'd88: uop = u(OP_ASR, SRC_R3, SRC_CONST, 3'd3, 32'd4);
            7'd89: uop = u(OP_SUB, SRC_R2, SRC_R3, 3'd2, 32'd0);
            default: uop = u(OP_ADD, SRC_ZERO, SRC_ZERO, 3'd5, 32'd0);
        endcase
    end

    assign tdo = (at_reg != TEMP_SKIP);
    assign pdo = (ap_reg != PRESS_SKIP);
    assign hdo = (ah_reg != HUM_SKIP);

    // humidity clamp on the final value
    always_comb
    begin
        hx = rf[2];
        if (hx[31])
            hx = '0;
        if (hx > HUM_MAX)
            hx = HUM_MAX;
    end

    esc_alu u_alu (
        .clk    (clk),
        .en     (en),
        .uop    (uop),
        .ld     (ld),
        .ld_dst (ld_dst),
        .ld_val (ld_val),
        .rf     (rf)
    );

    esc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
            fine_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            fine_reg  <= fine_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_ch.valid)
        begin
            at_reg  <= in_ch.adc_temp;
            ap_reg  <= in_ch.adc_press;
            ah_reg  <= in_ch.adc_hum;
            t_reg   <= '0;
            p_reg   <= '0;
            h_reg   <= '0;
            tok_reg <= 1'b0;
            pok_reg <= 1'b0;
            hok_reg <= 1'b0;
        end
        else if (state_reg == ST_RUN)
        begin
            if (pc_reg == T_END)
            begin
                t_reg   <= rf[1];
                tok_reg <= 1'b1;
            end
            if (pc_reg == P_END)
            begin
                p_reg   <= rf[2];
                pok_reg <= 1'b1;
            end
            if (pc_reg == H_END)
            begin
                h_reg   <= hx[28:12];
                hok_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        fine_next  = fine_reg;
        en         = 1'b0;
        ld         = 1'b0;
        ld_dst     = 3'd0;
        ld_val     = '0;
        dreq.start = 1'b0;
        dreq.num   = rf[2][31] ? rf[2] : {rf[2][30:0], 1'b0};
        dreq.den   = rf[1];
        case (state_reg)
            ST_IDLE:
            begin
                ld     = 1'b1;
                ld_dst = 3'd7;
                ld_val = fine_reg;
                if (in_ch.valid)
                begin
                    state_next = ST_RUN;
                    pc_next    = T_LD;
                end
            end
            ST_RUN:
            begin
                en = 1'b1;
                if (pc_reg == T_LD)
                begin
                    en      = 1'b0;
                    pc_next = P_LD;
                    if (tdo)
                    begin
                        ld      = 1'b1;
                        ld_dst  = 3'd0;
                        ld_val  = {12'd0, at_reg};
                        pc_next = T_BEG;
                    end
                end
                else if (pc_reg == P_LD)
                begin
                    en      = 1'b0;
                    pc_next = H_LD;
                    if (pdo)
                    begin
                        ld      = 1'b1;
                        ld_dst  = 3'd0;
                        ld_val  = {12'd0, ap_reg};
                        pc_next = P_BEG;
                    end
                end
                else if (pc_reg == H_LD)
                begin
                    en = 1'b0;
                    if (hdo)
                    begin
                        ld      = 1'b1;
                        ld_dst  = 3'd6;
                        ld_val  = {16'd0, ah_reg};
                        pc_next = H_BEG;
                    end
                    else
                        state_next = ST_OUT;
                end
                else if (pc_reg == T_END)
                begin
                    en        = 1'b0;
                    fine_next = rf[7];
                    pc_next   = P_LD;
                end
                else if (pc_reg == P_DEN)
                begin
                    if (rf[1] == 32'd0)
                        pc_next = H_LD;
                    else
                    begin
                        dreq.start = 1'b1;
                        state_next = ST_DIV;
                    end
                end
                else if (pc_reg == P_END)
                begin
                    en      = 1'b0;
                    pc_next = H_LD;
                end
                else if (pc_reg == H_END)
                begin
                    en         = 1'b0;
                    state_next = ST_OUT;
                end
                else
                    pc_next = pc_reg + 7'd1;
            end
            ST_DIV:
            begin
                if (drsp.done)
                begin
                    ld         = 1'b1;
                    ld_dst     = 3'd2;
                    ld_val     = rf[2][31] ? (drsp.quo << 1) : drsp.quo;
                    state_next = ST_RUN;
                    pc_next    = P_DIV;
                end
            end
            ST_OUT:
            begin
                if (out_ch.ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign in_ch.ready       = (state_reg == ST_IDLE);
    assign out_ch.valid      = (state_reg == ST_OUT);
    assign out_ch.temp_centi = t_reg;
    assign out_ch.press_pa   = p_reg;
    assign out_ch.hum_q10    = h_reg;
    assign out_ch.temp_ok    = tok_reg;
    assign out_ch.press_ok   = pok_reg;
    assign out_ch.hum_ok     = hok_reg;
    assign busy              = (state_reg != ST_IDLE);

endmodule

/* rtl/core/env_sensor_compensation.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// env_sensor_compensation
// integer compensation of raw temperature, pressure and humidity readings
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. All arithmetic runs through a
// single shared 32-bit alu (one operation per cycle, paused while the divider
// works) under a microcode sequencer, with a one-bit-per-cycle divider for
// pressure. An item passes through temperature, pressure with its division,
// humidity and an output state, then back to idle, where the next input is
// accepted. A skipped channel is passed over at its load step, and a zero
// pressure divisor skips the division and ends pressure; the input is not
// ready until the result is taken.
// Trim registers are written through the cfg channel, which is always ready.
// ----------------------------------------------------------------------------
module env_sensor_compensation
    import esc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    esc_in_if.sink     in_ch,
    esc_out_if.source  out_ch,
    esc_cfg_if.sink    cfg
);

    logic [47:0] temp_trim_reg, press_a_reg, press_b_reg, press_c_reg;
    logic [63:0] hum_trim_reg;
    logic        busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_trim_reg <= '0;
            press_a_reg   <= '0;
            press_b_reg   <= '0;
            press_c_reg   <= '0;
            hum_trim_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_TEMP_TRIM: temp_trim_reg <= cfg.data[47:0];
                REG_PRESS_A:   press_a_reg   <= cfg.data[47:0];
                REG_PRESS_B:   press_b_reg   <= cfg.data[47:0];
                REG_PRESS_C:   press_c_reg   <= cfg.data[47:0];
                REG_HUM_TRIM:  hum_trim_reg  <= cfg.data;
                default:       ;
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    esc_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .temp_trim (temp_trim_reg),
        .press_a   (press_a_reg),
        .press_b   (press_b_reg),
        .press_c   (press_c_reg),
        .hum_trim  (hum_trim_reg),
        .busy      (busy)
    );

`ifndef ASSERT_OFF
    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_ch.ready) else $error("input ready while busy");
    a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> busy) else $error("result without item");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> busy) else $error("accept lost");
`endif

endmodule

/* dv/env_sensor_compensation_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// env_sensor_compensation_tb
// self-checking bench: directed table then random readings under several trim
// sets, each result compared field by field with an integer predictor
// ----------------------------------------------------------------------------
module env_sensor_compensation_tb;
    import esc_pkg::*;

    typedef struct packed {
        logic [31:0] temp_centi;
        logic [31:0] press_pa;
        logic [16:0] hum_q10;
        logic        temp_ok;
        logic        press_ok;
        logic        hum_ok;
    } comp_result_t;

    typedef struct {
        logic [19:0] at;
        logic [19:0] ap;
        logic [15:0] ah;
        bit          typed;
        comp_result_t res;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    esc_in_if  in_ch();
    esc_out_if out_ch();
    esc_cfg_if cfg();

    env_sensor_compensation DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch.sink),
        .out_ch(out_ch.source),
        .cfg   (cfg.sink)
    );

    always #2 clk = ~clk;

    // predictor state
    logic [47:0] m_temp_trim, m_press_a, m_press_b, m_press_c;
    logic [63:0] m_hum_trim;
    logic [31:0] m_fine;

    comp_result_t readings_q[$];
    int errors = 0;
    int send_idle = 9;
    int recv_idle = 76;

    function automatic logic [31:0] asr(logic [31:0] x, int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [31:0] sx16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic comp_result_t compensate(logic [19:0] at, logic [19:0] ap,
                                                logic [15:0] ah);
        comp_result_t r;
        logic [31:0] t1, t2, t3, v1, v2, d, q, sq, p, pp;
        logic [31:0] h1, h2, h3, h4, h5, h6, x, a, b, c, e, s;
        r = '0;
        if (at != TEMP_SKIP)
        begin
            t1 = {16'd0, m_temp_trim[15:0]};
            t2 = sx16(m_temp_trim[31:16]);
            t3 = sx16(m_temp_trim[47:32]);
            v1 = asr((({12'd0, at} >> 3) - (t1 << 1)) * t2, 11);
            d = ({12'd0, at} >> 4) - t1;
            v2 = asr(asr(d * d, 12) * t3, 14);
            m_fine = v1 + v2;
            r.temp_centi = asr(m_fine * 32'd5 + 32'd128, 8);
            r.temp_ok = 1'b1;
        end
        if (ap != PRESS_SKIP)
        begin
            v1 = asr(m_fine, 1) - 32'd64000;
            q = asr(v1, 2);
            sq = q * q;
            v2 = asr(sq, 11) * sx16(m_press_b[47:32]);
            v2 = v2 + ((v1 * sx16(m_press_b[31:16])) << 1);
            v2 = asr(v2, 2) + (sx16(m_press_b[15:0]) << 16);
            v1 = asr(asr(sx16(m_press_a[47:32]) * asr(sq, 13), 3)
                     + asr(sx16(m_press_a[31:16]) * v1, 1), 18);
            v1 = asr((32'd32768 + v1) * {16'd0, m_press_a[15:0]}, 15);
            if (v1 != 0)
            begin
                p = ((32'd1048576 - {12'd0, ap}) - asr(v2, 12)) * 32'd3125;
                if (p < 32'h80000000) p = (p << 1) / v1;
                else p = (p / v1) * 32'd2;
                q = p >> 3;
                pp = (q * q) >> 13;
                v1 = asr(sx16(m_press_c[47:32]) * pp, 12);
                v2 = asr((p >> 2) * sx16(m_press_c[31:16]), 13);
                r.press_pa = p + asr(v1 + v2 + sx16(m_press_c[15:0]), 4);
                r.press_ok = 1'b1;
            end
        end
        if (ah != HUM_SKIP)
        begin
            h1 = {24'd0, m_hum_trim[7:0]};
            h2 = sx16(m_hum_trim[23:8]);
            h3 = {24'd0, m_hum_trim[31:24]};
            h4 = {{20{m_hum_trim[43]}}, m_hum_trim[43:32]};
            h5 = {{20{m_hum_trim[55]}}, m_hum_trim[55:44]};
            h6 = {{24{m_hum_trim[63]}}, m_hum_trim[63:56]};
            x = m_fine - 32'd76800;
            a = asr(({16'd0, ah} << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
            b = asr(x * h6, 10);
            c = asr(x * h3, 11) + 32'd32768;
            d = asr(b * c, 10) + 32'd2097152;
            e = asr(d * h2 + 32'd8192, 14);
            x = a * e;
            s = asr(x, 15);
            x = x - asr(asr(s * s, 7) * h1, 4);
            if (x[31]) x = 0;
            if (x > HUM_MAX) x = HUM_MAX;
            r.hum_q10 = x[28:12];
            r.hum_ok = 1'b1;
        end
        return r;
    endfunction

    task automatic write_trim(logic [2:0] idx, logic [63:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge clk); while (!cfg.ready);
        case (idx)
            REG_TEMP_TRIM: m_temp_trim = val[47:0];
            REG_PRESS_A:   m_press_a = val[47:0];
            REG_PRESS_B:   m_press_b = val[47:0];
            REG_PRESS_C:   m_press_c = val[47:0];
            REG_HUM_TRIM:  m_hum_trim = val;
            default: ;
        endcase
    endtask

    task automatic load_trims(logic [63:0] t, logic [63:0] pa, logic [63:0] pb,
                              logic [63:0] pc, logic [63:0] h);
        write_trim(REG_TEMP_TRIM, t);
        write_trim(REG_PRESS_A, pa);
        write_trim(REG_PRESS_B, pb);
        write_trim(REG_PRESS_C, pc);
        write_trim(REG_HUM_TRIM, h);
        cfg.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (readings_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // sends one reading; when a typed value is given it replaces the prediction
    task automatic send_reading(logic [19:0] at, logic [19:0] ap, logic [15:0] ah,
                                bit typed, comp_result_t typed_res);
        comp_result_t r;
        while ($urandom_range(99) < send_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.adc_temp  <= at;
        in_ch.adc_press <= ap;
        in_ch.adc_hum   <= ah;
        do @(posedge clk); while (!in_ch.ready);
        r = compensate(at, ap, ah);
        if (typed && r != typed_res)
        begin
            $display("%0t: table row disagrees with predictor exp=%h got=%h",
                     $time, typed_res, r);
            errors++;
        end
        readings_q.push_back(typed ? typed_res : r);
    endtask

    // output side
    always @(posedge clk)
    begin
        comp_result_t act, exp_r;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                act = '{out_ch.temp_centi, out_ch.press_pa, out_ch.hum_q10,
                        out_ch.temp_ok, out_ch.press_ok, out_ch.hum_ok};
                if (readings_q.size() == 0)
                begin
                    $display("%0t: unexpected transaction %h", $time, act);
                    errors++;
                end
                else
                begin
                    exp_r = readings_q.pop_front();
                    if (act.temp_centi !== exp_r.temp_centi)
                        $display("%0t: temp_centi exp=%h act=%h", $time,
                                 exp_r.temp_centi, act.temp_centi);
                    if (act.press_pa !== exp_r.press_pa)
                        $display("%0t: press_pa exp=%h act=%h", $time,
                                 exp_r.press_pa, act.press_pa);
                    if (act.hum_q10 !== exp_r.hum_q10)
                        $display("%0t: hum_q10 exp=%h act=%h", $time,
                                 exp_r.hum_q10, act.hum_q10);
                    if (act.temp_ok !== exp_r.temp_ok || act.press_ok !== exp_r.press_ok
                        || act.hum_ok !== exp_r.hum_ok)
                        $display("%0t: flags exp=%b%b%b act=%b%b%b", $time,
                                 exp_r.temp_ok, exp_r.press_ok, exp_r.hum_ok,
                                 act.temp_ok, act.press_ok, act.hum_ok);
                    if (act !== exp_r) errors++;
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial
    begin
        #4000000;
        $display("env_sensor_compensation_tb failed");
        $finish;
    end

    function automatic logic [19:0] rand_adc20();
        case ($urandom_range(5))
            0: return 20'($urandom);
            1: return 20'h00000;
            2: return 20'hFFFFF;
            3: return TEMP_SKIP;
            default: return 20'($urandom_range(20'hA0000, 20'h60000));
        endcase
    endfunction

    function automatic logic [15:0] rand_adc16();
        case ($urandom_range(5))
            0: return 16'($urandom);
            1: return 16'h0000;
            2: return 16'hFFFF;
            3: return HUM_SKIP;
            default: return 16'($urandom_range(16'h9000, 16'h5000));
        endcase
    endfunction

    initial
    begin
        stim_row_t rows[$];
        comp_result_t z;
        logic [63:0] rt, rpa, rpb, rpc, rh;
        logic [19:0] at, ap;
        logic [15:0] ah;
        int n;
        in_ch.valid = 1'b0;
        in_ch.adc_temp = '0;
        in_ch.adc_press = '0;
        in_ch.adc_hum = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        out_ch.ready = 1'b0;
        m_temp_trim = '0; m_press_a = '0; m_press_b = '0; m_press_c = '0;
        m_hum_trim = '0; m_fine = '0;
        z = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset all trims are zero: pressure divisor is zero
        rows.push_back('{TEMP_SKIP, PRESS_SKIP, HUM_SKIP, 1'b1, z});
        rows.push_back('{20'h00000, 20'h00000, HUM_SKIP, 1'b1, '{0, 0, 0, 1, 0, 0}});
        rows.push_back('{20'hFFFFF, 20'hFFFFF, 16'h0000, 1'b0, z});
        foreach (rows[i]) send_reading(rows[i].at, rows[i].ap, rows[i].ah,
                                       rows[i].typed, rows[i].res);
        wait_drained();

        // typical trim set
        load_trims({16'd50, 16'd26435, 16'd27504}, {-16'sd10685, 16'd36477, 16'd0} |
                   {16'hD6D0, 16'h0000, 16'd0} | 48'd36477,
                   {16'hFFF9, 16'd140, 16'd2855}, {16'd6000, 16'hD811, 16'd15500},
                   {8'd30, 12'd50, 12'd313, 8'd0, 16'd364, 8'd75});
        rows.delete();
        rows.push_back('{20'h80001, 20'h5A3C0, 16'h6B00, 1'b0, z});
        rows.push_back('{TEMP_SKIP, 20'h5A3C0, 16'h6B00, 1'b0, z});
        rows.push_back('{20'h00000, 20'h00000, 16'h0000, 1'b0, z});
        rows.push_back('{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b0, z});
        rows.push_back('{20'h7FFFF, 20'h7FFFF, 16'h7FFF, 1'b0, z});
        rows.push_back('{20'h55555, 20'hAAAAA, 16'h5555, 1'b0, z});
        rows.push_back('{20'hAAAAA, 20'h55555, 16'hAAAA, 1'b0, z});
        rows.push_back('{20'h7E000, PRESS_SKIP, HUM_SKIP, 1'b0, z});
        foreach (rows[i]) send_reading(rows[i].at, rows[i].ap, rows[i].ah, 1'b0, z);
        wait_drained();

        // extreme trims, all ones then sign bits only in the 48-bit sets
        load_trims('1, '1, '1, '1, '1);
        send_reading(20'h7FFFF, 20'h00000, 16'hFFFF, 1'b0, z);
        send_reading(20'h00000, 20'hFFFFF, 16'h0000, 1'b0, z);
        wait_drained();
        load_trims(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000,
                   48'h8000_8000_8000, 64'h8080_0800_8080_8080);
        send_reading(20'hFFFFF, 20'h12345, 16'h8001, 1'b0, z);
        send_reading(20'h00001, 20'h80001, 16'h7FFF, 1'b0, z);
        wait_drained();

        // random phases with fresh trim sets
        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph == 3) begin send_idle = 76; recv_idle = 9; end
            if (ph == 6) begin send_idle = 0; recv_idle = 0; end
            rt  = {$urandom, $urandom};
            rpa = {$urandom, $urandom};
            rpb = {$urandom, $urandom};
            rpc = {$urandom, $urandom};
            rh  = {$urandom, $urandom};
            if (ph % 2 == 0)
            begin
                // near-typical magnitudes keep divisor and formulas in range
                rt  = {$urandom_range(65535), 16'($urandom_range(30000, 20000)),
                       16'($urandom_range(33000, 25000))};
                rpa[15:0] = 16'($urandom_range(40000, 30000));
                rh[23:8] = 16'($urandom_range(400, 300));
            end
            load_trims(rt, rpa, rpb, rpc, rh);
            n = 150;
            for (int k = 0; k < n; k++)
            begin
                at = rand_adc20();
                ap = rand_adc20();
                if (ap == PRESS_SKIP && $urandom_range(1)) ap = 20'($urandom);
                ah = rand_adc16();
                send_reading(at, ap, ah, 1'b0, z);
                if (k == 75 && ph == 1) wait_drained();
            end
            wait_drained();
        end

        repeat (200) @(posedge clk);
        if (errors == 0 && readings_q.size() == 0)
            $display("env_sensor_compensation_tb passed");
        else
            $display("env_sensor_compensation_tb failed");
        $finish;
    end
endmodule

/* files.f */
rtl/core/esc_pkg.sv
rtl/core/esc_if.sv
rtl/core/esc_div.sv
rtl/core/esc_alu.sv
rtl/core/esc_seq.sv
rtl/core/env_sensor_compensation.sv
dv/env_sensor_compensation_tb.sv
